[design/wash_program_sequencer_unit_macros.svh]
// ----------------------------------------------------------------------------
// wash program sequencer assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef WASH_PROGRAM_SEQUENCER_UNIT_MACROS_SVH
`define WASH_PROGRAM_SEQUENCER_UNIT_MACROS_SVH

// assertion on an explicit clock and active-low reset
`define WPS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion on the block clock and reset
`define WPS_ASSERT(label, prop, msg) \
  `WPS_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

[design/wps_pkg.sv]
// ----------------------------------------------------------------------------
// wps_pkg
// types, phase and program codes, register map of the wash program sequencer
// ----------------------------------------------------------------------------
package wps_pkg;

  localparam int unsigned TimeW    = 16;
  localparam int unsigned CountW   = 4;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned ProgW    = 2;
  localparam int unsigned MotionW  = 5;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned RegIdxW  = 3;

  // phase codes
  localparam logic [PhaseW-1:0] PH_IDLE  = 3'd0;
  localparam logic [PhaseW-1:0] PH_FILL  = 3'd1;
  localparam logic [PhaseW-1:0] PH_DET   = 3'd2;
  localparam logic [PhaseW-1:0] PH_RIGHT = 3'd3;
  localparam logic [PhaseW-1:0] PH_LEFT  = 3'd4;
  localparam logic [PhaseW-1:0] PH_DRAIN = 3'd5;

  // program codes
  localparam logic [ProgW-1:0] PG_NONE     = 2'd0;
  localparam logic [ProgW-1:0] PG_COMPLETE = 2'd1;
  localparam logic [ProgW-1:0] PG_RINSE    = 2'd2;
  localparam logic [ProgW-1:0] PG_DRY      = 2'd3;

  // actuator masks, one bit each
  localparam logic [MotionW-1:0] M_WATER = 5'b00001;
  localparam logic [MotionW-1:0] M_DET   = 5'b00010;
  localparam logic [MotionW-1:0] M_DRAIN = 5'b00100;
  localparam logic [MotionW-1:0] M_RIGHT = 5'b01000;
  localparam logic [MotionW-1:0] M_LEFT  = 5'b10000;

  // register indexes
  localparam logic [RegIdxW-1:0] REG_FILL   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_DET    = 3'd1;
  localparam logic [RegIdxW-1:0] REG_TURN   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_DRAIN  = 3'd3;
  localparam logic [RegIdxW-1:0] REG_REPEAT = 3'd4;
  localparam logic [RegIdxW-1:0] REG_BLINK  = 3'd5;

  // register reset values
  localparam logic [TimeW-1:0]  RST_FILL   = 16'd3000;
  localparam logic [TimeW-1:0]  RST_DET    = 16'd2000;
  localparam logic [TimeW-1:0]  RST_TURN   = 16'd5000;
  localparam logic [TimeW-1:0]  RST_DRAIN  = 16'd5000;
  localparam logic [CountW-1:0] RST_REPEAT = 4'd5;
  localparam logic [TimeW-1:0]  RST_BLINK  = 16'd1000;

  typedef struct packed {
    logic start_button;
    logic stop_switch;
    logic select_complete;
    logic select_rinse;
    logic select_dry;
  } in_item_t;

  typedef struct packed {
    logic              water_valve;
    logic              detergent_valve;
    logic              drain_valve;
    logic              motor_right;
    logic              motor_left;
    logic              standby_led;
    logic [PhaseW-1:0] phase;
    logic [ProgW-1:0]  program_res;
  } out_item_t;

  typedef struct packed {
    logic [TimeW-1:0]  fill_time_ms;
    logic [TimeW-1:0]  detergent_time_ms;
    logic [TimeW-1:0]  wash_turn_time_ms;
    logic [TimeW-1:0]  drain_time_ms;
    logic [CountW-1:0] wash_repeats;
    logic [TimeW-1:0]  blink_half_period_ms;
  } cfg_t;

  function automatic logic [TimeW-1:0] sat_inc(input logic [TimeW-1:0] v);
    return (v == {TimeW{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

[design/wps_if.sv]
// ----------------------------------------------------------------------------
// wps channel interfaces
// valid/ready channels for tick items in and result items out
// ----------------------------------------------------------------------------
interface wps_in_if;
  logic               valid;
  logic               ready;
  wps_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wps_out_if;
  logic               valid;
  logic               ready;
  wps_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/wash_program_sequencer_unit.sv]
// an accepted tick item is held in the input register, and its result is then registered in the result register
// throughput: one tick item per cycle while the result channel is not stalled, set by the state update
// an input register and a result register part the two channels
// reset: asynchronous active low; idle, no program, timers and wash count
// cleared, all actuators and the standby led off, registers at defaults
// ----------------------------------------------------------------------------
// wash_program_sequencer_unit
// washing programme sequencer driven by millisecond tick items
// ----------------------------------------------------------------------------
module wash_program_sequencer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wps_in_if.sink                        in_i,
  wps_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wps_pkg::CfgAddrW-1:0]  paddr,
  input  logic [wps_pkg::CfgDataW-1:0]  pwdata,
  output logic [wps_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  wps_pkg::cfg_t      cfg;
  wps_pkg::in_item_t  s1_item_q;
  wps_pkg::out_item_t out_item_q;
  wps_pkg::out_item_t res;
  logic               s1_valid_q;
  logic               out_valid_q;
  logic               advance;
  logic               step_en;

  assign pready = 1'b1;

  wps_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // result register free or being emptied this cycle
  assign advance    = !out_valid_q || out_o.ready;
  assign step_en    = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= in_i.data;
    end
    if (step_en) begin
      out_item_q <= res;
    end
  end

  wps_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step_en),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

endmodule

[design/wps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// wps_cfg_regs
// apb-style register bank holding step times, repeat count and blink period
// ----------------------------------------------------------------------------
module wps_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [wps_pkg::CfgAddrW-1:0]    paddr_i,
  input  logic [wps_pkg::CfgDataW-1:0]    pwdata_i,
  output logic [wps_pkg::CfgDataW-1:0]    prdata_o,
  output wps_pkg::cfg_t                   cfg_o
);

  wps_pkg::cfg_t                  cfg_q;
  logic                           wr_en;
  logic [wps_pkg::RegIdxW-1:0]    idx;

  assign wr_en = psel_i & penable_i & pwrite_i;
  assign idx   = paddr_i[wps_pkg::CfgAddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fill_time_ms         <= wps_pkg::RST_FILL;
      cfg_q.detergent_time_ms    <= wps_pkg::RST_DET;
      cfg_q.wash_turn_time_ms    <= wps_pkg::RST_TURN;
      cfg_q.drain_time_ms        <= wps_pkg::RST_DRAIN;
      cfg_q.wash_repeats         <= wps_pkg::RST_REPEAT;
      cfg_q.blink_half_period_ms <= wps_pkg::RST_BLINK;
    end else if (wr_en) begin
      unique case (idx)
        wps_pkg::REG_FILL:   cfg_q.fill_time_ms <= pwdata_i[wps_pkg::TimeW-1:0];
        wps_pkg::REG_DET:    cfg_q.detergent_time_ms <= pwdata_i[wps_pkg::TimeW-1:0];
        wps_pkg::REG_TURN:   cfg_q.wash_turn_time_ms <= pwdata_i[wps_pkg::TimeW-1:0];
        wps_pkg::REG_DRAIN:  cfg_q.drain_time_ms <= pwdata_i[wps_pkg::TimeW-1:0];
        wps_pkg::REG_REPEAT: cfg_q.wash_repeats <= pwdata_i[wps_pkg::CountW-1:0];
        wps_pkg::REG_BLINK:  cfg_q.blink_half_period_ms <= pwdata_i[wps_pkg::TimeW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    unique case (idx)
      wps_pkg::REG_FILL:   prdata_o[wps_pkg::TimeW-1:0] = cfg_q.fill_time_ms;
      wps_pkg::REG_DET:    prdata_o[wps_pkg::TimeW-1:0] = cfg_q.detergent_time_ms;
      wps_pkg::REG_TURN:   prdata_o[wps_pkg::TimeW-1:0] = cfg_q.wash_turn_time_ms;
      wps_pkg::REG_DRAIN:  prdata_o[wps_pkg::TimeW-1:0] = cfg_q.drain_time_ms;
      wps_pkg::REG_REPEAT: prdata_o[wps_pkg::CountW-1:0] = cfg_q.wash_repeats;
      wps_pkg::REG_BLINK:  prdata_o[wps_pkg::TimeW-1:0] = cfg_q.blink_half_period_ms;
      default: begin
      end
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[design/wps_step.sv]
// ----------------------------------------------------------------------------
// wps_step
// sequencer state and its per-tick update: phase, program, timers, actuators
// ----------------------------------------------------------------------------
module wps_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  wps_pkg::in_item_t   item_i,
  input  wps_pkg::cfg_t       cfg_i,
  output wps_pkg::out_item_t  res_o
);

  logic [wps_pkg::PhaseW-1:0]  phase_q, phase_d;
  logic [wps_pkg::ProgW-1:0]   prog_q, prog_d;
  logic [wps_pkg::TimeW-1:0]   step_q, step_d;
  logic [wps_pkg::TimeW-1:0]   blink_q, blink_d;
  logic [wps_pkg::CountW-1:0]  wash_q, wash_d;
  logic [wps_pkg::MotionW-1:0] mot_q, mot_d;
  logic                        led_q, led_d;
  logic [wps_pkg::TimeW-1:0]   step_inc;
  logic [wps_pkg::TimeW-1:0]   blink_inc;

  always_comb begin
    blink_inc = wps_pkg::sat_inc(blink_q);
    step_inc  = (phase_q != wps_pkg::PH_IDLE) ? wps_pkg::sat_inc(step_q) : step_q;

    phase_d = phase_q;
    prog_d  = prog_q;
    step_d  = step_inc;
    blink_d = blink_inc;
    wash_d  = wash_q;
    mot_d   = mot_q;
    led_d   = led_q;

    if (item_i.stop_switch) begin
      if (phase_q != wps_pkg::PH_IDLE) begin
        mot_d   = '0;
        phase_d = wps_pkg::PH_IDLE;
      end
    end else begin
      if (phase_q == wps_pkg::PH_IDLE) begin
        // blink before the program latch
        if (blink_inc >= cfg_i.blink_half_period_ms) begin
          led_d   = ~led_q;
          blink_d = '0;
        end
        priority if (item_i.select_complete) begin
          prog_d = wps_pkg::PG_COMPLETE;
        end else if (item_i.select_rinse) begin
          prog_d = wps_pkg::PG_RINSE;
        end else if (item_i.select_dry) begin
          prog_d = wps_pkg::PG_DRY;
        end else begin
          prog_d = wps_pkg::PG_NONE;
        end
      end

      if (prog_d != wps_pkg::PG_NONE) begin
        unique case (phase_q)
          wps_pkg::PH_IDLE: begin
            if (item_i.start_button) begin
              if (prog_d == wps_pkg::PG_COMPLETE || prog_d == wps_pkg::PG_RINSE) begin
                mot_d   = mot_q | wps_pkg::M_WATER;
                phase_d = wps_pkg::PH_FILL;
                step_d  = '0;
              end else begin
                wash_d  = '0;
                mot_d   = wps_pkg::M_RIGHT;
                phase_d = wps_pkg::PH_RIGHT;
                step_d  = '0;
              end
            end
          end
          wps_pkg::PH_FILL: begin
            if (step_inc >= cfg_i.fill_time_ms) begin
              if (prog_d == wps_pkg::PG_COMPLETE) begin
                mot_d   = (mot_q & ~wps_pkg::M_WATER) | wps_pkg::M_DET;
                phase_d = wps_pkg::PH_DET;
              end else begin
                wash_d  = '0;
                mot_d   = wps_pkg::M_RIGHT;
                phase_d = wps_pkg::PH_RIGHT;
              end
              step_d = '0;
            end
          end
          wps_pkg::PH_DET: begin
            if (step_inc >= cfg_i.detergent_time_ms) begin
              wash_d  = '0;
              mot_d   = wps_pkg::M_RIGHT;
              phase_d = wps_pkg::PH_RIGHT;
              step_d  = '0;
            end
          end
          wps_pkg::PH_RIGHT: begin
            if (step_inc >= cfg_i.wash_turn_time_ms) begin
              mot_d   = wps_pkg::M_LEFT;
              phase_d = wps_pkg::PH_LEFT;
              step_d  = '0;
            end
          end
          wps_pkg::PH_LEFT: begin
            if (step_inc >= cfg_i.wash_turn_time_ms) begin
              // another right-left pair or on to drain
              if (wash_q < cfg_i.wash_repeats) begin
                wash_d  = wash_q + 1'b1;
                mot_d   = wps_pkg::M_RIGHT;
                phase_d = wps_pkg::PH_RIGHT;
              end else begin
                wash_d  = '0;
                mot_d   = wps_pkg::M_DRAIN;
                phase_d = wps_pkg::PH_DRAIN;
              end
              step_d = '0;
            end
          end
          wps_pkg::PH_DRAIN: begin
            if (step_inc >= cfg_i.drain_time_ms) begin
              mot_d   = '0;
              phase_d = wps_pkg::PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wps_pkg::PH_IDLE;
      prog_q  <= wps_pkg::PG_NONE;
      step_q  <= '0;
      blink_q <= '0;
      wash_q  <= '0;
      mot_q   <= '0;
      led_q   <= 1'b0;
    end else if (en_i) begin
      phase_q <= phase_d;
      prog_q  <= prog_d;
      step_q  <= step_d;
      blink_q <= blink_d;
      wash_q  <= wash_d;
      mot_q   <= mot_d;
      led_q   <= led_d;
    end
  end

  assign res_o.water_valve     = |(mot_d & wps_pkg::M_WATER);
  assign res_o.detergent_valve = |(mot_d & wps_pkg::M_DET);
  assign res_o.drain_valve     = |(mot_d & wps_pkg::M_DRAIN);
  assign res_o.motor_right     = |(mot_d & wps_pkg::M_RIGHT);
  assign res_o.motor_left      = |(mot_d & wps_pkg::M_LEFT);
  assign res_o.standby_led     = led_d;
  assign res_o.phase           = phase_d;
  assign res_o.program_res     = prog_d;

endmodule

[design/wps_checker.sv]
// ----------------------------------------------------------------------------
// wps_checker
// port-level checks on the result channel of the sequencer
// ----------------------------------------------------------------------------
`include "wash_program_sequencer_unit_macros.svh"

module wps_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input wps_pkg::out_item_t out_item_i
);

  logic [wps_pkg::MotionW-1:0] motion;

  assign motion = {out_item_i.motor_left, out_item_i.motor_right, out_item_i.drain_valve,
                   out_item_i.detergent_valve, out_item_i.water_valve};

  // stalled result holds
  `WPS_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i), "result changed while stalled")

  // never two actuators driven at once
  `WPS_ASSERT(a_motion_onehot, out_valid_i |-> $onehot0(motion), "more than one actuator on")

  // idle means every actuator off
  `WPS_ASSERT(a_idle_quiet, out_valid_i && out_item_i.phase == wps_pkg::PH_IDLE |-> motion == '0, "actuator on while idle")

  // a running sequence always has a program
  `WPS_ASSERT(a_run_prog, out_valid_i && out_item_i.phase != wps_pkg::PH_IDLE |-> out_item_i.program_res != wps_pkg::PG_NONE, "running without a program")

endmodule

bind wash_program_sequencer_unit wps_checker u_wps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.data)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// wash program sequencer testbench: millisecond tick items go in through a
// valid/ready channel and the actuator levels that come back are checked
// against a cycle-free model of the programme sequence, under several register
// settings and with random idling on both channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    wps_pkg::in_item_t  tick;
    logic               typed;
    wps_pkg::out_item_t lv;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [wps_pkg::CfgAddrW-1:0] paddr;
  logic [wps_pkg::CfgDataW-1:0] pwdata;
  logic [wps_pkg::CfgDataW-1:0] prdata;
  logic                         pready;

  wps_in_if  in_ch ();
  wps_out_if out_ch ();

  wash_program_sequencer_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // model state, starts at the reset values of the block
  wps_pkg::cfg_t               cfg      = '{wps_pkg::RST_FILL, wps_pkg::RST_DET,
                                            wps_pkg::RST_TURN, wps_pkg::RST_DRAIN,
                                            wps_pkg::RST_REPEAT, wps_pkg::RST_BLINK};
  logic [wps_pkg::PhaseW-1:0]  ph_st    = wps_pkg::PH_IDLE;
  logic [wps_pkg::ProgW-1:0]   prog     = wps_pkg::PG_NONE;
  logic [wps_pkg::TimeW-1:0]   step_ms  = '0;
  logic [wps_pkg::CountW-1:0]  washes   = '0;
  logic [wps_pkg::TimeW-1:0]   blink_ms = '0;
  logic [wps_pkg::MotionW-1:0] motion   = '0;
  logic                        led      = 1'b0;

  wps_pkg::out_item_t levels_q [$];
  wps_pkg::out_item_t predicted_lv;
  logic               tick_typed;
  wps_pkg::out_item_t tick_typed_lv;
  int                 err_cnt   = 0;
  int                 ticks_sent = 0;
  bit                 idle_en;
  bit                 hold_req;

  // directed ticks at reset settings; typed rows carry their own levels
  dir_row_t dir_rows [17] = '{
    '{5'b00000, 1'b1, {6'b000000, wps_pkg::PH_IDLE,  wps_pkg::PG_NONE}},
    '{5'b11111, 1'b1, {6'b000000, wps_pkg::PH_IDLE,  wps_pkg::PG_NONE}},
    '{5'b10000, 1'b1, {6'b000000, wps_pkg::PH_IDLE,  wps_pkg::PG_NONE}},
    '{5'b00100, 1'b1, {6'b000000, wps_pkg::PH_IDLE,  wps_pkg::PG_COMPLETE}},
    '{5'b01010, 1'b1, {6'b000000, wps_pkg::PH_IDLE,  wps_pkg::PG_COMPLETE}},
    '{5'b10111, 1'b1, {6'b100000, wps_pkg::PH_FILL,  wps_pkg::PG_COMPLETE}},
    '{5'b00011, 1'b1, {6'b100000, wps_pkg::PH_FILL,  wps_pkg::PG_COMPLETE}},
    '{5'b11000, 1'b1, {6'b000000, wps_pkg::PH_IDLE,  wps_pkg::PG_COMPLETE}},
    '{5'b10011, 1'b1, {6'b100000, wps_pkg::PH_FILL,  wps_pkg::PG_RINSE}},
    '{5'b01000, 1'b1, {6'b000000, wps_pkg::PH_IDLE,  wps_pkg::PG_RINSE}},
    '{5'b10001, 1'b1, {6'b000100, wps_pkg::PH_RIGHT, wps_pkg::PG_DRY}},
    '{5'b00000, 1'b1, {6'b000100, wps_pkg::PH_RIGHT, wps_pkg::PG_DRY}},
    '{5'b01000, 1'b1, {6'b000000, wps_pkg::PH_IDLE,  wps_pkg::PG_DRY}},
    '{5'b10000, 1'b1, {6'b000000, wps_pkg::PH_IDLE,  wps_pkg::PG_NONE}},
    '{5'b10100, 1'b0, '0},
    '{5'b00001, 1'b0, '0},
    '{5'b01111, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void enter_step(input logic [wps_pkg::PhaseW-1:0] ph,
                                     input logic [wps_pkg::MotionW-1:0] m);
    ph_st   = ph;
    motion  = m;
    step_ms = '0;
  endfunction

  // one millisecond of the programme sequence, returns the levels after it
  function automatic wps_pkg::out_item_t advance_sequencer(input wps_pkg::in_item_t t);
    wps_pkg::out_item_t lv;
    if (blink_ms != '1) blink_ms++;
    if (ph_st != wps_pkg::PH_IDLE && step_ms != '1) step_ms++;
    if (t.stop_switch) begin
      if (ph_st != wps_pkg::PH_IDLE) begin
        motion = '0;
        ph_st  = wps_pkg::PH_IDLE;
      end
    end else begin
      if (ph_st == wps_pkg::PH_IDLE) begin
        if (blink_ms >= cfg.blink_half_period_ms) begin
          led      = ~led;
          blink_ms = '0;
        end
        if (t.select_complete) prog = wps_pkg::PG_COMPLETE;
        else if (t.select_rinse) prog = wps_pkg::PG_RINSE;
        else if (t.select_dry) prog = wps_pkg::PG_DRY;
        else prog = wps_pkg::PG_NONE;
      end
      if (prog != wps_pkg::PG_NONE) begin
        case (ph_st)
          wps_pkg::PH_IDLE: begin
            if (t.start_button) begin
              if (prog == wps_pkg::PG_DRY) begin
                washes = '0;
                enter_step(wps_pkg::PH_RIGHT, wps_pkg::M_RIGHT);
              end else begin
                enter_step(wps_pkg::PH_FILL, motion | wps_pkg::M_WATER);
              end
            end
          end
          wps_pkg::PH_FILL: begin
            if (step_ms >= cfg.fill_time_ms) begin
              if (prog == wps_pkg::PG_COMPLETE) begin
                enter_step(wps_pkg::PH_DET, (motion & ~wps_pkg::M_WATER) | wps_pkg::M_DET);
              end else begin
                washes = '0;
                enter_step(wps_pkg::PH_RIGHT, wps_pkg::M_RIGHT);
              end
            end
          end
          wps_pkg::PH_DET: begin
            if (step_ms >= cfg.detergent_time_ms) begin
              washes = '0;
              enter_step(wps_pkg::PH_RIGHT, wps_pkg::M_RIGHT);
            end
          end
          wps_pkg::PH_RIGHT: begin
            if (step_ms >= cfg.wash_turn_time_ms) begin
              enter_step(wps_pkg::PH_LEFT, wps_pkg::M_LEFT);
            end
          end
          wps_pkg::PH_LEFT: begin
            if (step_ms >= cfg.wash_turn_time_ms) begin
              if (washes < cfg.wash_repeats) begin
                washes++;
                enter_step(wps_pkg::PH_RIGHT, wps_pkg::M_RIGHT);
              end else begin
                washes = '0;
                enter_step(wps_pkg::PH_DRAIN, wps_pkg::M_DRAIN);
              end
            end
          end
          wps_pkg::PH_DRAIN: begin
            // drain end keeps the step counter, only the levels drop
            if (step_ms >= cfg.drain_time_ms) begin
              motion = '0;
              ph_st  = wps_pkg::PH_IDLE;
            end
          end
          default: ;
        endcase
      end
    end
    lv.water_valve     = |(motion & wps_pkg::M_WATER);
    lv.detergent_valve = |(motion & wps_pkg::M_DET);
    lv.drain_valve     = |(motion & wps_pkg::M_DRAIN);
    lv.motor_right     = |(motion & wps_pkg::M_RIGHT);
    lv.motor_left      = |(motion & wps_pkg::M_LEFT);
    lv.standby_led     = led;
    lv.phase           = ph_st;
    lv.program_res     = prog;
    return lv;
  endfunction

  task automatic check_field(input string name, input logic [2:0] e, input logic [2:0] a);
    if (a !== e) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      err_cnt++;
    end
  endtask

  task automatic check_levels(input wps_pkg::out_item_t e, input wps_pkg::out_item_t a);
    check_field("water_valve", 3'(e.water_valve), 3'(a.water_valve));
    check_field("detergent_valve", 3'(e.detergent_valve), 3'(a.detergent_valve));
    check_field("drain_valve", 3'(e.drain_valve), 3'(a.drain_valve));
    check_field("motor_right", 3'(e.motor_right), 3'(a.motor_right));
    check_field("motor_left", 3'(e.motor_left), 3'(a.motor_left));
    check_field("standby_led", 3'(e.standby_led), 3'(a.standby_led));
    check_field("phase", e.phase, a.phase);
    check_field("program_res", 3'(e.program_res), 3'(a.program_res));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (levels_q.size() == 0) begin
          $error("result item with no expectation waiting");
          err_cnt++;
        end else begin
          check_levels(levels_q.pop_front(), out_ch.data);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predicted_lv = advance_sequencer(in_ch.data);
        levels_q.push_back(tick_typed ? tick_typed_lv : predicted_lv);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (79) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_tick(input wps_pkg::in_item_t t, input logic typed,
                           input wps_pkg::out_item_t lv);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 17)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid   <= 1'b1;
    in_ch.data    <= t;
    tick_typed    <= typed;
    tick_typed_lv <= lv;
    do @(posedge clk_i); while (!in_ch.ready);
    ticks_sent++;
  endtask

  task automatic wait_results_done();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (levels_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [wps_pkg::RegIdxW-1:0] idx,
                           input logic [wps_pkg::CfgDataW-1:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= wps_pkg::CfgAddrW'({idx, 2'b00});
    pwdata  <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_regs(input wps_pkg::cfg_t c);
    write_reg(wps_pkg::REG_FILL, wps_pkg::CfgDataW'(c.fill_time_ms));
    write_reg(wps_pkg::REG_DET, wps_pkg::CfgDataW'(c.detergent_time_ms));
    write_reg(wps_pkg::REG_TURN, wps_pkg::CfgDataW'(c.wash_turn_time_ms));
    write_reg(wps_pkg::REG_DRAIN, wps_pkg::CfgDataW'(c.drain_time_ms));
    write_reg(wps_pkg::REG_REPEAT, wps_pkg::CfgDataW'(c.wash_repeats));
    write_reg(wps_pkg::REG_BLINK, wps_pkg::CfgDataW'(c.blink_half_period_ms));
    cfg = c;
  endtask

  function automatic wps_pkg::cfg_t rand_regs(input int tmax, input int rmax, input int bmax);
    wps_pkg::cfg_t c;
    c.fill_time_ms         = wps_pkg::TimeW'($urandom_range(0, tmax));
    c.detergent_time_ms    = wps_pkg::TimeW'($urandom_range(0, tmax));
    c.wash_turn_time_ms    = wps_pkg::TimeW'($urandom_range(0, tmax));
    c.drain_time_ms        = wps_pkg::TimeW'($urandom_range(0, tmax));
    c.wash_repeats         = wps_pkg::CountW'($urandom_range(0, rmax));
    c.blink_half_period_ms = wps_pkg::TimeW'($urandom_range(1, bmax));
    return c;
  endfunction

  function automatic int step_ticks(input logic [wps_pkg::TimeW-1:0] t);
    return (t == 0) ? 1 : int'(t);
  endfunction

  // a few idle ticks, a start with a chosen programme, then the run itself
  task automatic run_wash_cycle(input int cap);
    wps_pkg::in_item_t t;
    int                run_len;
    repeat ($urandom_range(0, 3)) begin
      t              = wps_pkg::in_item_t'(5'($urandom_range(0, 31)));
      t.stop_switch  = ($urandom_range(0, 5) == 0);
      t.start_button = ($urandom_range(0, 3) == 0);
      send_tick(t, 1'b0, '0);
    end
    t              = wps_pkg::in_item_t'(5'($urandom_range(0, 31)));
    t.start_button = 1'b1;
    t.stop_switch  = 1'b0;
    case ($urandom_range(0, 9))
      0: {t.select_complete, t.select_rinse, t.select_dry} = 3'b000;
      1, 2, 3: t.select_complete = 1'b1;
      4, 5, 6: {t.select_complete, t.select_rinse} = 2'b01;
      default: {t.select_complete, t.select_rinse, t.select_dry} = 3'b001;
    endcase
    send_tick(t, 1'b0, '0);
    run_len = step_ticks(cfg.fill_time_ms) + step_ticks(cfg.detergent_time_ms)
            + 2 * (int'(cfg.wash_repeats) + 1) * step_ticks(cfg.wash_turn_time_ms)
            + step_ticks(cfg.drain_time_ms) + int'($urandom_range(0, 4));
    if (run_len > cap) run_len = cap;
    repeat (run_len) begin
      t             = wps_pkg::in_item_t'(5'($urandom_range(0, 31)));
      t.stop_switch = ($urandom_range(0, 59) == 0);
      send_tick(t, 1'b0, '0);
    end
  endtask

  task automatic run_phase(input wps_pkg::cfg_t c, input int n, input int cap,
                           input bit gaps, input bit squeeze);
    int first;
    bit held;
    bit paused;
    wait_results_done();
    load_regs(c);
    idle_en = gaps;
    first   = ticks_sent;
    held    = 1'b0;
    paused  = 1'b0;
    while (ticks_sent - first < n) begin
      if (squeeze && !held && ticks_sent - first > n / 3) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (squeeze && !paused && ticks_sent - first > 2 * n / 3) begin
        paused = 1'b1;
        wait_results_done();
      end
      run_wash_cycle(cap);
    end
  endtask

  initial begin
    wps_pkg::cfg_t c;
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    tick_typed    = 1'b0;
    tick_typed_lv = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    idle_en       = 1'b1;
    hold_req      = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].lv);

    // every step over on the next tick, no extra wash pairs, fastest blink
    run_phase('{16'd0, 16'd0, 16'd0, 16'd0, 4'd0, 16'd1}, 180, 40, 1'b1, 1'b0);
    run_phase(rand_regs(6, 3, 9), 350, 120, 1'b1, 1'b1);
    c              = rand_regs(2, 0, 4);
    c.wash_repeats = 4'd15;
    run_phase(c, 280, 120, 1'b0, 1'b0);
    // longest steps never end here, only stop gets the machine back to idle
    run_phase('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF}, 120, 40,
              1'b1, 1'b0);
    run_phase(rand_regs(8, 15, 12), 270, 120, 1'b1, 1'b0);
    run_phase(rand_regs(5, 4, 6), 100, 80, 1'b0, 1'b0);

    wait_results_done();
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
